### sv/owbm_pkg.sv
// Package for the 1-Wire bus master: beat types, phase codes, register map.
`default_nettype none

package owbm_pkg;

    localparam int TICK_W    = 10;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_WR_LEAD   = 4'd4,
        PH_WR_HOLD   = 4'd5,
        PH_RD_LEAD   = 4'd6,
        PH_RD_SETTLE = 4'd7,
        PH_RD_TAIL   = 4'd8,
        PH_GAP       = 4'd9
    } phase_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RESET_LOW      = 3'd0,
        REG_PRESENCE_WAIT  = 3'd1,
        REG_RESET_RECOVERY = 3'd2,
        REG_WRITE_LEAD     = 3'd3,
        REG_WRITE_HOLD     = 3'd4,
        REG_READ_LEAD      = 3'd5,
        REG_READ_SETTLE    = 3'd6,
        REG_READ_TAIL      = 3'd7
    } reg_idx_t;

    typedef logic [TICK_W-1:0] tick_t;

    localparam tick_t REG_DEFAULTS [NUM_REGS] = '{
        10'd500, 10'd70, 10'd500, 10'd10, 10'd50, 10'd5, 10'd5, 10'd50
    };

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_data;
        logic       line_in;
    } in_beat_t;

    typedef struct packed {
        logic       line_release;
        logic       busy_res;
        logic       done_res;
        logic       presence_detected;
        logic [7:0] read_data;
    } out_beat_t;

endpackage

`default_nettype wire

### sv/one_wire_bus_master_core.sv
// Top level of the tick-driven 1-Wire bus master.
//
// Usage:
//   Each input beat on s_* is one timer tick: it carries the sampled bus
//   level and an optional command (reset pulse, byte write, byte read).
//   A command is taken only while the sequencer is idle; otherwise it is
//   ignored and the beat acts as a plain tick.
//   Each tick yields one result beat on m_*: the line drive for that tick,
//   busy/done flags, the last presence answer and the last byte read.
//   The result beat is registered from its accepted input beat. One beat is
//   accepted every cycle; the result register is the only buffer, so while
//   the receiver stalls with a result pending, s_ready drops and the
//   sequencer holds.
//   Write the eight tick-count registers (cfg_wr_en, cfg_index, cfg_wdata)
//   only while no tick is in flight; the block does not enforce this.
//   Synchronous reset: sequencer idle, flags and bytes cleared, tick
//   registers back to their defaults, no result pending.
`default_nettype none

module one_wire_bus_master_core
    import owbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data
);

    tick_t     cfg_reg [NUM_REGS];

    phase_t    phase_reg,         phase_next;
    tick_t     tick_count_reg,    tick_count_next;
    logic [2:0] bit_index_reg,    bit_index_next;
    logic [1:0] op_kind_reg,      op_kind_next;
    logic [7:0] shift_byte_reg,   shift_byte_next;
    logic [7:0] read_byte_reg,    read_byte_next;
    logic       presence_reg,     presence_next;
    logic       m_valid_reg;
    out_beat_t  m_data_reg,       m_data_next;

    logic       accept;
    phase_t     ph;
    phase_t     follow;
    reg_idx_t   sel;
    logic       use_reg;
    tick_t      len;
    logic [TICK_W:0] tc_inc;
    logic       release_bit;
    logic       done_bit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ph              = phase_reg;
        op_kind_next    = op_kind_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        read_byte_next  = read_byte_reg;
        presence_next   = presence_reg;
        release_bit     = 1'b1;
        done_bit        = 1'b0;
        follow          = PH_IDLE;
        sel             = REG_RESET_LOW;
        use_reg         = 1'b0;

        if (ph == PH_IDLE && s_data.command != CMD_TICK) begin
            op_kind_next    = s_data.command;
            tick_count_next = '0;
            bit_index_next  = '0;
            unique case (s_data.command)
                CMD_RESET: ph = PH_RST_LOW;
                CMD_WRITE: begin
                    shift_byte_next = s_data.write_data;
                    ph              = PH_WR_LEAD;
                end
                default: begin
                    shift_byte_next = '0;
                    ph              = PH_RD_LEAD;
                end
            endcase
        end

        unique case (ph)
            PH_RST_LOW: begin
                release_bit = 1'b0;
                sel = REG_RESET_LOW; use_reg = 1'b1; follow = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                sel = REG_PRESENCE_WAIT; use_reg = 1'b1; follow = PH_RST_REC;
            end
            PH_RST_REC: begin
                if (tick_count_next == '0) begin
                    presence_next = !s_data.line_in;
                end
                sel = REG_RESET_RECOVERY; use_reg = 1'b1; follow = PH_IDLE;
            end
            PH_WR_LEAD: begin
                release_bit = 1'b0;
                sel = REG_WRITE_LEAD; use_reg = 1'b1; follow = PH_WR_HOLD;
            end
            PH_WR_HOLD: begin
                release_bit = shift_byte_next[bit_index_next];
                sel = REG_WRITE_HOLD; use_reg = 1'b1; follow = PH_GAP;
            end
            PH_RD_LEAD: begin
                release_bit = 1'b0;
                sel = REG_READ_LEAD; use_reg = 1'b1; follow = PH_RD_SETTLE;
            end
            PH_RD_SETTLE: begin
                sel = REG_READ_SETTLE; use_reg = 1'b1; follow = PH_RD_TAIL;
            end
            PH_RD_TAIL: begin
                if (tick_count_next == '0 && s_data.line_in) begin
                    shift_byte_next[bit_index_next] = 1'b1;
                end
                sel = REG_READ_TAIL; use_reg = 1'b1; follow = PH_GAP;
            end
            PH_GAP: begin
                if (bit_index_next == 3'd7 ||
                    (op_kind_next != CMD_WRITE && op_kind_next != CMD_READ)) begin
                    follow = PH_IDLE;
                    if (op_kind_next == CMD_READ) begin
                        read_byte_next = shift_byte_next;
                    end
                end else begin
                    follow = (op_kind_next == CMD_READ) ? PH_RD_LEAD : PH_WR_LEAD;
                    bit_index_next = bit_index_next + 3'd1;
                end
            end
            default: ph = PH_IDLE;
        endcase

        len = TICK_W'(1);
        if (use_reg && cfg_reg[sel] != '0) begin
            len = cfg_reg[sel];
        end
        tc_inc = {1'b0, tick_count_next} + (TICK_W+1)'(1);

        if (ph != PH_IDLE) begin
            if (tc_inc >= {1'b0, len}) begin
                tick_count_next = '0;
                done_bit        = (follow == PH_IDLE);
                ph              = follow;
            end else begin
                tick_count_next = tc_inc[TICK_W-1:0];
            end
        end

        phase_next                    = ph;
        m_data_next.line_release      = release_bit;
        m_data_next.busy_res          = (ph != PH_IDLE);
        m_data_next.done_res          = done_bit;
        m_data_next.presence_detected = presence_next;
        m_data_next.read_data         = read_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= REG_DEFAULTS[i];
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            op_kind_reg    <= '0;
            shift_byte_reg <= '0;
            read_byte_reg  <= '0;
            presence_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                op_kind_reg    <= op_kind_next;
                shift_byte_reg <= shift_byte_next;
                read_byte_reg  <= read_byte_next;
                presence_reg   <= presence_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
